FILE: design/kmus_pkg.sv
// ---------------------------------------------------------------------------
// kmus_pkg: shared types and constants for the unique-select merge
// Field widths, result kinds, head status codes and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package kmus_pkg;

	// Fixed field widths of the stream payloads
	localparam int SRC_W      = 3;
	localparam int KEY_W      = 64;
	localparam int MASK_W     = 8;
	localparam int KIND_W     = 2;
	localparam int IN_DATA_W  = 72;  // source + key, padded to bytes
	localparam int OUT_DATA_W = 80;  // source_res + key_res + written_mask, padded

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_EMIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REFILL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	// Per-source head status
	typedef enum logic [1:0] {
		HS_WAIT  = 2'd0,
		HS_VALID = 2'd1,
		HS_ENDED = 2'd2
	} head_stat_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // apply the accepted refill item
		logic scan_clr;   // restart the minimum scan
		logic scan_step;  // look at one more head
		logic match_cap;  // capture the set of sources holding the minimum
		logic commit;     // record last key, send matching sources back to wait
		logic emit;       // load an emit result
		logic req;        // load one refill request
		logic finish;     // load the finish result
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic any_wait;
		logic any_valid;
		logic scan_last;
		logic emit_ok;
		logic req_last;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: design/kway_merge_unique_select.sv
// ---------------------------------------------------------------------------
// kway_merge_unique_select: k-way merge keeping keys unique to one source
// Top level: stream ports, controller and datapath.
// ---------------------------------------------------------------------------
// Usage: each input item on s_* refills one waiting source with its next key
// (s_tuser low) or marks it ended (s_tuser high). Once no source waits, the
// block scans the heads for the smallest key, emits it (m_tuser = emit) when
// exactly one source holds it and it differs from the previous minimum, then
// sends one refill request per source that held it. With every source ended,
// each item yields one finish result carrying the written mask. m_tlast marks
// the last result caused by an item.
// Sequence: an item that leaves some source waiting returns to idle after the
// check. A merge step runs the check, the serial head scan, match capture, the
// emit decision and the refill requests; the emit result loads in the decision
// cycle, and the scan uses one comparator over one head per cycle.
// A new item is taken only once the previous one has finished its results.
// Results sit in a single output register; a stall on m_tready holds the
// result there and pauses the controller, nothing is dropped.
// Reset: all sources waiting, no last key, written mask clear, output empty.
// ---------------------------------------------------------------------------
module kway_merge_unique_select import kmus_pkg::*; #(
	parameter int SOURCES  = 8,
	parameter int KEY_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] source, [66:3] key, rest zero
	input  logic                  s_tuser,   // [0] is_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] source_res, [66:3] key_res,
	                                         // [74:67] written_mask, rest zero
	output logic [KIND_W-1:0]     m_tuser,   // [1:0] kind
	output logic                  m_tlast
);

	ctl_cmd_t          cmd;
	dp_sts_t           sts;
	logic [SRC_W-1:0]  res_source;
	logic [KEY_W-1:0]  res_key;
	logic [MASK_W-1:0] res_mask;

	kmus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kmus_dp #(
		.SOURCES  (SOURCES),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_source  (s_tdata[SRC_W-1:0]),
		.in_key     (s_tdata[SRC_W+KEY_W-1:SRC_W]),
		.in_is_end  (s_tuser),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (m_tuser),
		.out_source (res_source),
		.out_key    (res_key),
		.out_mask   (res_mask),
		.out_last   (m_tlast)
	);

	// Pack the result fields
	assign m_tdata = {{(OUT_DATA_W - SRC_W - KEY_W - MASK_W){1'b0}},
	                  res_mask, res_key, res_source};

	// Results load only into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.req || cmd.finish) |-> sts.out_free)
		else $error("result loaded while output register busy");

	// At most one result per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit, cmd.req, cmd.finish}))
		else $error("more than one result loaded in a cycle");

	// Refills apply only on an accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (s_tvalid && s_tready))
		else $error("refill applied without an accepted item");

	// A finish result is always the last one of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (m_tvalid && m_tlast && m_tuser == KIND_FINISH))
		else $error("finish result not presented as last");

endmodule

FILE: design/kmus_dp.sv
// ---------------------------------------------------------------------------
// kmus_dp: merge datapath
// Head key and status registers, serial minimum scan, match capture, the
// last-key record, written flags and the output result register.
// ---------------------------------------------------------------------------
module kmus_dp import kmus_pkg::*; #(
	parameter int SOURCES  = 8,
	parameter int KEY_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output dp_sts_t           sts,
	input  logic [SRC_W-1:0]  in_source,
	input  logic [KEY_W-1:0]  in_key,
	input  logic              in_is_end,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [KIND_W-1:0] out_kind,
	output logic [SRC_W-1:0]  out_source,
	output logic [KEY_W-1:0]  out_key,
	output logic [MASK_W-1:0] out_mask,
	output logic              out_last
);

	localparam int IW = $clog2(SOURCES);

	logic [KEY_BITS-1:0] head_key_q [SOURCES];
	head_stat_t          head_stat_q [SOURCES];
	logic [KEY_BITS-1:0] min_q;
	logic                min_valid_q;
	logic [IW-1:0]       scan_q;
	logic [SOURCES-1:0]  match_q;
	logic [SOURCES-1:0]  match_d;
	logic [SOURCES-1:0]  written_q;
	logic [KEY_BITS-1:0] last_key_q;
	logic                last_valid_q;
	logic [IW-1:0]       low_idx;
	logic [MASK_W-1:0]   mask_d;
	logic                match_single;

	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SRC_W-1:0]  out_source_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              out_last_q;

	// Summaries of the head status and the captured match set
	always_comb begin
		sts.any_wait  = 1'b0;
		sts.any_valid = 1'b0;
		for (int i = 0; i < SOURCES; i++) begin
			if (head_stat_q[i] == HS_WAIT)
				sts.any_wait = 1'b1;
			if (head_stat_q[i] == HS_VALID)
				sts.any_valid = 1'b1;
		end
		match_single  = (match_q != '0) && ((match_q & (match_q - SOURCES'(1))) == '0);
		sts.scan_last = (scan_q == IW'(SOURCES - 1));
		sts.emit_ok   = match_single && (!last_valid_q || (last_key_q != min_q));
		sts.req_last  = match_single;
		sts.out_free  = !out_valid_q || out_ready;
	end

	// Sources holding the minimum, and the lowest of them
	always_comb begin
		low_idx = '0;
		for (int i = 0; i < SOURCES; i++)
			match_d[i] = (head_stat_q[i] == HS_VALID) && (head_key_q[i] == min_q);
		for (int i = SOURCES - 1; i >= 0; i--) begin
			if (match_q[i])
				low_idx = IW'(i);
		end
	end

	// Written mask over the addressable sources
	always_comb begin
		mask_d = '0;
		for (int i = 0; i < SOURCES && i < MASK_W; i++)
			mask_d[i] = written_q[i];
	end

	// Head keys: written by refills only
	always_ff @(posedge clk) begin
		for (int i = 0; i < SOURCES; i++) begin
			if (cmd.load && !in_is_end && (int'(in_source) == i) &&
			    (head_stat_q[i] == HS_WAIT))
				head_key_q[i] <= in_key[KEY_BITS-1:0];
		end
	end

	// Head status: refill, end marker, back to wait on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCES; i++)
				head_stat_q[i] <= HS_WAIT;
		end else begin
			for (int i = 0; i < SOURCES; i++) begin
				if (cmd.load && (int'(in_source) == i) && (head_stat_q[i] == HS_WAIT))
					head_stat_q[i] <= in_is_end ? HS_ENDED : HS_VALID;
				else if (cmd.commit && match_q[i])
					head_stat_q[i] <= HS_WAIT;
			end
		end
	end

	// Minimum scan, one head per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			min_valid_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_q      <= '0;
			min_valid_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + IW'(1);
			if (head_stat_q[scan_q] == HS_VALID &&
			    (!min_valid_q || head_key_q[scan_q] < min_q))
				min_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && head_stat_q[scan_q] == HS_VALID &&
		    (!min_valid_q || head_key_q[scan_q] < min_q))
			min_q <= head_key_q[scan_q];
	end

	// Match set: captured after the scan, one bit dropped per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			match_q <= '0;
		else if (cmd.match_cap)
			match_q <= match_d;
		else if (cmd.req)
			match_q <= match_q & (match_q - SOURCES'(1));
	end

	// Last key seen and written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q   <= '0;
			last_valid_q <= 1'b0;
			written_q    <= '0;
		end else begin
			if (cmd.commit) begin
				last_key_q   <= min_q;
				last_valid_q <= 1'b1;
			end
			if (cmd.emit)
				written_q <= written_q | match_q;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.req || cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q   <= KIND_EMIT;
			out_source_q <= SRC_W'(low_idx);
			out_key_q    <= KEY_W'(min_q);
			out_mask_q   <= '0;
			out_last_q   <= 1'b0;
		end else if (cmd.req) begin
			out_kind_q   <= KIND_REFILL;
			out_source_q <= SRC_W'(low_idx);
			out_key_q    <= '0;
			out_mask_q   <= '0;
			out_last_q   <= match_single;
		end else if (cmd.finish) begin
			out_kind_q   <= KIND_FINISH;
			out_source_q <= '0;
			out_key_q    <= '0;
			out_mask_q   <= mask_d;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_source = out_source_q;
	assign out_key    = out_key_q;
	assign out_mask   = out_mask_q;
	assign out_last   = out_last_q;

endmodule

FILE: design/kmus_ctrl.sv
// ---------------------------------------------------------------------------
// kmus_ctrl: merge controller
// Sequences refill, readiness check, minimum scan, match capture, emit
// decision, refill requests and the finish result.
// ---------------------------------------------------------------------------
module kmus_ctrl import kmus_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_MATCH = 7'b0001000,
		S_EMIT  = 7'b0010000,
		S_REQ   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.any_wait)
					state_d = S_IDLE;
				else if (!sts.any_valid)
					state_d = S_FIN;
				else begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_d = S_MATCH;
			end
			S_MATCH: begin
				cmd.match_cap = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.emit_ok) begin
					cmd.commit = 1'b1;
					state_d    = S_REQ;
				end else if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.commit = 1'b1;
					state_d    = S_REQ;
				end
			end
			S_REQ: begin
				if (sts.out_free) begin
					cmd.req = 1'b1;
					if (sts.req_last)
						state_d = S_IDLE;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for kway_merge_unique_select
// Drives refill and end items into the merge over the input stream and keeps
// a cycle-free model of the heads, the last key and the written flags. Each
// accepted item adds its expected results to a queue; a monitor compares every
// result item field by field. One merge run is driven from reset to finish:
// directed corner cases, sorted streams with random content and noise with a
// drain pause, a long output stall, then the end of every source and repeated
// finish results.
// ---------------------------------------------------------------------------
module testbench;
	import kmus_pkg::*;

	localparam int NSRC      = 8;
	localparam int CLK_HALF  = 6;
	localparam int TAIL      = 40;      // cycles after the last result
	localparam int LIMIT     = 300000;  // watchdog, in cycles
	localparam int LONG_HOLD = 400;     // long output stall, in cycles

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SRC_W-1:0]  src;
		logic [KEY_W-1:0]  key;
		logic [MASK_W-1:0] mask;
		logic              last;
	} merge_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;

	// model state
	logic [KEY_W-1:0] head_key [NSRC];
	head_stat_t       head_stat [NSRC];
	logic [KEY_W-1:0] prev_min;
	bit               prev_min_seen;
	logic [MASK_W-1:0] written;

	merge_res_t  pending_res[$];
	logic [KEY_W-1:0] stream_pos [NSRC];
	int          live_items;
	int          fail_count;
	int          cycle_count;
	int          sink_hold;
	bit          idle_on;

	kway_merge_unique_select u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Apply one accepted item to the model and queue the results it causes
	task automatic merge_predict(input logic [SRC_W-1:0] src, input logic [KEY_W-1:0] key,
			input logic is_end);
		merge_res_t       step_q[$];
		merge_res_t       r;
		logic [KEY_W-1:0] min_key;
		int               min_src;
		int               holders;
		bit               found;
		found = 0;
		min_key = '0;
		min_src = 0;
		holders = 0;
		if (head_stat[src] == HS_WAIT) begin
			live_items++;
			if (is_end) begin
				head_stat[src] = HS_ENDED;
			end else begin
				head_key[src] = key;
				head_stat[src] = HS_VALID;
			end
		end
		foreach (head_stat[i])
			if (head_stat[i] == HS_WAIT)
				return;
		// find the smallest head among valid sources
		foreach (head_stat[i]) begin
			if (head_stat[i] == HS_VALID && (!found || head_key[i] < min_key)) begin
				min_key = head_key[i];
				min_src = i;
				found = 1;
			end
		end
		if (!found) begin
			live_items++;
			r = '{KIND_FINISH, '0, '0, written, 1'b1};
			pending_res.push_back(r);
			return;
		end
		foreach (head_stat[i])
			if (head_stat[i] == HS_VALID && head_key[i] == min_key)
				holders++;
		if (holders == 1 && (!prev_min_seen || prev_min != min_key)) begin
			r = '{KIND_EMIT, SRC_W'(min_src), min_key, '0, 1'b0};
			step_q.push_back(r);
			written[min_src] = 1'b1;
		end
		prev_min = min_key;
		prev_min_seen = 1;
		// every source holding the minimum goes back to waiting
		foreach (head_stat[i]) begin
			if (head_stat[i] == HS_VALID && head_key[i] == min_key) begin
				head_stat[i] = HS_WAIT;
				r = '{KIND_REFILL, SRC_W'(i), '0, '0, 1'b0};
				step_q.push_back(r);
			end
		end
		step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			pending_res.push_back(step_q[i]);
	endtask

	// Offer one item, with an optional gap first, and hold it until accepted
	task automatic send_item(input logic [SRC_W-1:0] src, input logic [KEY_W-1:0] key,
			input logic is_end);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - KEY_W - SRC_W){1'b0}}, key, src};
		s_tuser <= is_end;
		do @(posedge clk); while (!s_tready);
		merge_predict(src, key, is_end);
	endtask

	// Stop offering and wait until every expected result has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	function automatic int pick_waiting();
		int cand[$];
		foreach (head_stat[i])
			if (head_stat[i] == HS_WAIT)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	function automatic int pick_busy();
		int cand[$];
		foreach (head_stat[i])
			if (head_stat[i] != HS_WAIT)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// Next key of a sorted stream; small steps make keys collide across sources
	function automatic logic [KEY_W-1:0] next_sorted_key(input int s);
		stream_pos[s] += KEY_W'($urandom_range(1, 3));
		return stream_pos[s];
	endfunction

	// One well-formed refill, an out-of-order key, or an item that is ignored
	task automatic send_mixed();
		int s;
		int b;
		int r;
		r = $urandom_range(0, 99);
		s = pick_waiting();
		if (r < 80) begin
			send_item(SRC_W'(s), next_sorted_key(s), 1'b0);
		end else if (r < 83) begin
			send_item(SRC_W'(s), {$urandom, $urandom}, 1'b0);
		end else begin
			b = pick_busy();
			if (b >= 0)
				send_item(SRC_W'(b), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
		end
	endtask

	// Corner cases: first key, ignored refill, shared minimum, repeat of the
	// last key, end with a nonzero key, extreme keys and sources
	task automatic test_directed();
		send_item(3'd0, 64'd0, 1'b0);
		send_item(3'd0, 64'd5, 1'b0);
		send_item(3'd1, 64'd50, 1'b0);
		send_item(3'd2, 64'd0, 1'b0);
		send_item(3'd3, 64'd10, 1'b0);
		send_item(3'd4, 64'd20, 1'b0);
		send_item(3'd5, 64'd30, 1'b0);
		send_item(3'd6, '1, 1'b1);
		send_item(3'd7, '1, 1'b0);
		send_item(3'd5, 64'd3, 1'b0);
		send_item(3'd0, 64'd0, 1'b0);
		send_item(3'd2, 64'd7, 1'b0);
		send_item(3'd0, 64'd7, 1'b0);
		send_item(3'd0, 64'd8, 1'b0);
		send_item(3'd2, 64'd9, 1'b0);
		send_item(3'd2, 64'd10, 1'b0);
		send_item(3'd7, 64'd1, 1'b1);
	endtask

	// Sorted streams with random content; pause once until drained
	task automatic test_random_streams();
		logic [KEY_W-1:0] base;
		base = ({$urandom, $urandom} >> 2) | 64'h100;
		foreach (stream_pos[i])
			stream_pos[i] = base;
		live_items = 0;
		while (live_items < 40)
			send_mixed();
		wait_drained();
		idle_on = 0;
		while (live_items < 60)
			send_mixed();
		idle_on = 1;
		while (live_items < 100)
			send_mixed();
	endtask

	// Stall the output for a long stretch while items keep coming
	task automatic test_output_stall();
		idle_on = 0;
		sink_hold = LONG_HOLD;
		live_items = 0;
		while (live_items < 30)
			send_mixed();
	endtask

	// End every source, then check that the finish result repeats
	task automatic test_finish();
		int s;
		s = pick_waiting();
		while (s >= 0) begin
			if ($urandom_range(0, 3) == 0)
				send_item(SRC_W'(s), next_sorted_key(s), 1'b0);
			else
				send_item(SRC_W'(s), {$urandom, $urandom}, 1'b1);
			s = pick_waiting();
		end
		send_item(3'd7, '1, 1'b0);
		send_item(3'd0, 64'd0, 1'b1);
		send_item(3'd5, {$urandom, $urandom}, 1'b0);
	endtask

	// Output side: random stalls, and the long hold when one is requested
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		merge_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				$error("unexpected result: kind %0d source_res %0d key_res %h",
					m_tuser, m_tdata[2:0], m_tdata[66:3]);
				fail_count++;
			end else begin
				want = pending_res.pop_front();
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[2:0] !== want.src) begin
					$error("source_res: expected %0d, got %0d", want.src, m_tdata[2:0]);
					fail_count++;
				end
				if (m_tdata[66:3] !== want.key) begin
					$error("key_res: expected %h, got %h", want.key, m_tdata[66:3]);
					fail_count++;
				end
				if (m_tdata[74:67] !== want.mask) begin
					$error("written_mask: expected %h, got %h", want.mask, m_tdata[74:67]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		fail_count = 0;
		sink_hold = 0;
		idle_on = 1;
		live_items = 0;
		prev_min = '0;
		prev_min_seen = 0;
		written = '0;
		foreach (head_stat[i]) begin
			head_stat[i] = HS_WAIT;
			head_key[i] = '0;
			stream_pos[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_streams();
		test_output_stall();
		idle_on = 0;
		test_finish();

		wait_drained();
		if (fail_count == 0 && pending_res.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: kway_merge_unique_select.f
design/kmus_pkg.sv
design/kmus_dp.sv
design/kmus_ctrl.sv
design/kway_merge_unique_select.sv
test/testbench.sv
